>>> hdl/fsob_pkg.sv
// Shared types, codes and constants of the fail-safe output bank.
package fsob_pkg;

   localparam int CHANNELS_DEF = 12;
   localparam int MAX_CHANNELS = 16;
   localparam int OUT_W        = 12;
   localparam int CHAN_W       = 4;
   localparam int ELAPSED_W    = 32;
   localparam int TIMEOUT_W    = 16;
   localparam int TICK_MS      = 100;
   localparam int THRESH_W     = 23;
   localparam int LOSS_MODE_W  = 24;
   localparam int SAFE_LEVEL_W = 12;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 64;
   localparam int TO_GROUPS    = 3;
   localparam int TO_PER_GROUP = 4;

   localparam logic [1:0] LOSS_HOLD = 2'd0;
   localparam logic [1:0] LOSS_SAFE = 2'd1;
   localparam logic [1:0] LOSS_OFF  = 2'd2;

   localparam logic [CSR_ADDR_W-1:0] CSR_LOSS_MODES    = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_SAFE_LEVELS   = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_TIMEOUTS_LOW  = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_TIMEOUTS_MID  = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_TIMEOUTS_HIGH = 3'd4;

   typedef enum logic [1:0] {
      OP_SET_ONE = 2'd0,
      OP_SET_ALL = 2'd1,
      OP_EVAL    = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef struct packed {
      logic [1:0]           loss_mode;
      logic                 safe_level;
      logic [TIMEOUT_W-1:0] timeout;
   } lane_cfg_type;

   typedef struct packed {
      op_type               op;
      logic                 selected;
      logic                 level;
      logic                 mask_bit;
      logic [ELAPSED_W-1:0] elapsed_ms;
   } lane_item_type;

   typedef struct packed {
      logic commanded;
      logic driven;
      logic latched;
   } lane_state_type;

endpackage

>>> hdl/fsob_lane.sv
// One output channel: its state bits and its link-loss trip check.
module fsob_lane (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  fsob_pkg::lane_item_type item,
   input  fsob_pkg::lane_cfg_type  cfg,
   output fsob_pkg::lane_state_type state_next
);
   import fsob_pkg::*;

   lane_state_type          state_ff;
   lane_state_type          state_in;
   logic [THRESH_W-1:0]     thresh;
   logic                    armed;
   logic                    expired;

   assign thresh  = THRESH_W'({{(THRESH_W-TIMEOUT_W){1'b0}}, cfg.timeout}
                              * THRESH_W'(TICK_MS));
   assign armed   = (cfg.loss_mode == LOSS_SAFE) || (cfg.loss_mode == LOSS_OFF);
   assign expired = item.elapsed_ms >= {{(ELAPSED_W-THRESH_W){1'b0}}, thresh};

   always_comb begin
      state_in = state_ff;
      case (item.op)
         OP_SET_ONE: begin
            if (item.selected) begin
               state_in.commanded = item.level;
               state_in.driven    = item.level;
               state_in.latched   = 1'b0;
            end
         end
         OP_SET_ALL: begin
            state_in.commanded = item.mask_bit;
            state_in.driven    = item.mask_bit;
            state_in.latched   = 1'b0;
         end
         OP_EVAL: begin
            if (armed && !state_ff.latched && expired) begin
               state_in.driven  = (cfg.loss_mode == LOSS_SAFE) && cfg.safe_level;
               state_in.latched = 1'b1;
            end
         end
         default: begin
            state_in = state_ff;
         end
      endcase
   end

   assign state_next = state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

endmodule

>>> hdl/fsob_merge.sv
// Gathers the lane results into the three masks and holds the result word.
module fsob_merge #(
   parameter int CHANNELS = fsob_pkg::CHANNELS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  accept,
   input  fsob_pkg::lane_state_type [CHANNELS-1:0] lane_next,
   input  logic                                  rsp_stall,
   output logic                                  rsp_valid,
   output logic [fsob_pkg::OUT_W-1:0]            rsp_driven_mask,
   output logic [fsob_pkg::OUT_W-1:0]            rsp_commanded_mask,
   output logic [fsob_pkg::OUT_W-1:0]            rsp_latched_mask
);
   import fsob_pkg::*;

   logic [OUT_W-1:0] driven_in;
   logic [OUT_W-1:0] commanded_in;
   logic [OUT_W-1:0] latched_in;
   logic [OUT_W-1:0] driven_ff;
   logic [OUT_W-1:0] commanded_ff;
   logic [OUT_W-1:0] latched_ff;
   logic             valid_ff;
   logic             valid_in;

   for (genvar i = 0; i < OUT_W; i++) begin : g_pack
      if (i < CHANNELS) begin : g_lane
         assign driven_in[i]    = lane_next[i].driven;
         assign commanded_in[i] = lane_next[i].commanded;
         assign latched_in[i]   = lane_next[i].latched;
      end else begin : g_pad
         assign driven_in[i]    = 1'b0;
         assign commanded_in[i] = 1'b0;
         assign latched_in[i]   = 1'b0;
      end
   end

   assign valid_in = accept || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         driven_ff    <= '0;
         commanded_ff <= '0;
         latched_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         if (accept) begin
            driven_ff    <= driven_in;
            commanded_ff <= commanded_in;
            latched_ff   <= latched_in;
         end
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_driven_mask    = driven_ff;
   assign rsp_commanded_mask = commanded_ff;
   assign rsp_latched_mask   = latched_ff;

endmodule

>>> hdl/fail_safe_output_bank.sv
// Top level of the fail-safe output bank: config registers, channel lanes, result register.
// The result word of an item appears in the cycle after its acceptance.
// Throughput: one word per cycle while not stalled; each lane's command or trip check is combinational.
// The result register accepts a new word whenever it is empty or being taken this cycle.
// Reset (synchronous, active high) clears all masks, config registers and the result valid;
// the input is stalled while reset is high.
module fail_safe_output_bank #(
   parameter int CHANNELS = fsob_pkg::CHANNELS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // input channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_mode,
   input  logic [fsob_pkg::CHAN_W-1:0]         req_channel,
   input  logic                                req_level,
   input  logic [fsob_pkg::OUT_W-1:0]          req_command_mask,
   input  logic [fsob_pkg::ELAPSED_W-1:0]      req_elapsed_ms,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [fsob_pkg::OUT_W-1:0]          rsp_driven_mask,
   output logic [fsob_pkg::OUT_W-1:0]          rsp_commanded_mask,
   output logic [fsob_pkg::OUT_W-1:0]          rsp_latched_mask,
   // configuration port
   input  logic                                csr_we,
   input  logic [fsob_pkg::CSR_ADDR_W-1:0]     csr_index,
   input  logic [fsob_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import fsob_pkg::*;

   // Config registers; the three timeout words sit in one array, four channels each.
   logic [LOSS_MODE_W-1:0]                 loss_modes_ff;
   logic [SAFE_LEVEL_W-1:0]                safe_levels_ff;
   logic [TO_GROUPS-1:0][CSR_DATA_W-1:0]   timeouts_ff;

   logic                                   accept;
   op_type                                 op;
   lane_state_type [CHANNELS-1:0]          lane_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         loss_modes_ff  <= '0;
         safe_levels_ff <= '0;
         timeouts_ff    <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_LOSS_MODES:    loss_modes_ff  <= csr_wdata[LOSS_MODE_W-1:0];
            CSR_SAFE_LEVELS:   safe_levels_ff <= csr_wdata[SAFE_LEVEL_W-1:0];
            CSR_TIMEOUTS_LOW:  timeouts_ff[0] <= csr_wdata;
            CSR_TIMEOUTS_MID:  timeouts_ff[1] <= csr_wdata;
            CSR_TIMEOUTS_HIGH: timeouts_ff[2] <= csr_wdata;
            default: begin
               // drop writes to unused indexes
            end
         endcase
      end
   end

   // Hold the input while the result register is full and blocked, and during reset.
   assign req_stall = reset || (rsp_valid && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign op        = op_type'(req_mode);

   // One lane per channel. Channels past the register coverage read as hold mode,
   // so they never trip.
   for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
      lane_cfg_type  cfg;
      lane_item_type item;

      if (i < OUT_W) begin : g_cfg
         assign cfg.loss_mode  = loss_modes_ff[2*i +: 2];
         assign cfg.safe_level = safe_levels_ff[i];
         assign cfg.timeout    =
            timeouts_ff[i / TO_PER_GROUP][TIMEOUT_W*(i % TO_PER_GROUP) +: TIMEOUT_W];
      end else begin : g_cfg_none
         assign cfg = '0;
      end

      // A single-channel command reaches only the lane it names; an index at or past
      // the lane count selects nothing and leaves the masks unchanged.
      assign item.op         = op;
      assign item.selected   = (req_channel == CHAN_W'(i));
      assign item.level      = req_level;
      assign item.mask_bit   = (i < OUT_W) ? req_command_mask[i % OUT_W] : 1'b0;
      assign item.elapsed_ms = req_elapsed_ms;

      fsob_lane u_lane (
         .clock      (clock),
         .reset      (reset),
         .accept     (accept),
         .item       (item),
         .cfg        (cfg),
         .state_next (lane_next[i])
      );
   end

   // Merge the lane results and hold the result word until it is taken.
   fsob_merge #(
      .CHANNELS (CHANNELS)
   ) u_merge (
      .clock              (clock),
      .reset              (reset),
      .accept             (accept),
      .lane_next          (lane_next),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_driven_mask    (rsp_driven_mask),
      .rsp_commanded_mask (rsp_commanded_mask),
      .rsp_latched_mask   (rsp_latched_mask)
   );

   // Every accepted word yields a result word in the next cycle.
   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted word produced no result");

   // A mask command clears every latch.
   a_set_all_clears_latch: assert property (@(posedge clock) disable iff (reset)
      (accept && op == OP_SET_ALL) |=> (rsp_latched_mask == '0))
      else $error("latch left set after mask command");

   // A link-loss evaluation never alters the commanded levels.
   a_eval_keeps_command: assert property (@(posedge clock) disable iff (reset)
      (accept && op == OP_EVAL) |=> (rsp_commanded_mask == $past(rsp_commanded_mask)))
      else $error("evaluation changed commanded mask");

   // A trip can only add latches; it never clears one.
   a_eval_keeps_latches: assert property (@(posedge clock) disable iff (reset)
      (accept && op == OP_EVAL) |=>
         ((rsp_latched_mask & $past(rsp_latched_mask)) == $past(rsp_latched_mask)))
      else $error("evaluation cleared a latch");

endmodule
